/* rtl/nmea_gsv_satellite_tracker_core_macros.svh */
// assertion macros for the gsv satellite tracker core
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef NMEA_GSV_SATELLITE_TRACKER_CORE_MACROS_SVH
`define NMEA_GSV_SATELLITE_TRACKER_CORE_MACROS_SVH

// same-cycle implication
`define NGST_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ngst assertion failed");

// next-cycle implication
`define NGST_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ngst assertion failed");

`endif

/* rtl/ngst_pkg.sv */
// shared constants, types and helper functions of the gsv satellite tracker
// no dependencies
`timescale 1ns / 1ps
package ngst_pkg;

  localparam int BUF_BYTES = 128;
  localparam int MAX_SATS  = 32;
  localparam int BUF_AW    = $clog2(BUF_BYTES);
  localparam int BCNT_W    = $clog2(BUF_BYTES + 1);
  localparam int SAT_AW    = (MAX_SATS > 1) ? $clog2(MAX_SATS) : 1;
  localparam int SCNT_W    = $clog2(MAX_SATS + 1);
  localparam int V_W       = 17;
  localparam int VX_W      = 20;
  localparam int unsigned FIELD_LIMIT = 99999;
  localparam logic [15:0] LOST_MAX    = 16'hFFFF;
  localparam logic [7:0]  CNO_MAX     = 8'd255;
  localparam logic [31:0] TTL_RESET   = 32'd10000;

  // characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_V      = 8'h56;

  // register indexes
  localparam logic REG_TTL = 1'b0;

  typedef enum logic [1:0] {
    ACT_FEED  = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_RSVD  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    S_IDLE, S_FEED, S_P1_RD, S_P1_DT, S_P1_END,
    S_P2_RD, S_P2_DT, S_SRCH, S_REUSE, S_Q
  } state_e;

  typedef struct packed {
    logic load;
    logic feed;
    logic p1_init;
    logic p1_step;
    logic p2_init;
    logic p2_step;
    logic k_clr;
    logic srch_step;
    logic reuse_step;
    logic q_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    action_e action;
    logic    go_parse;
    logic    p1_last;
    logic    cks_ok;
    logic    p2_store;
    logic    p2_end;
    logic    p2_end_q;
    logic    srch_done;
    logic    srch_full;
    logic    reuse_done;
    logic    q_done;
    logic    out_free;
  } sts_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] r;
    if (c <= 8'h39) r = c - 8'h30;
    else if (c <= 8'h46) r = c - 8'h37;
    else r = c - 8'h57;
    return r[3:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

/* rtl/ngst_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module ngst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/ngst_ctrl.sv */
// sequencing state machine of the gsv tracker
// depends on ngst_pkg
`timescale 1ns / 1ps
module ngst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ngst_pkg::sts_t sts_i,
  output ngst_pkg::cmd_t cmd_o
);
  import ngst_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.action == ACT_FEED) begin
            state_d = S_FEED;
          end else begin
            cmd_o.k_clr = 1'b1;
            state_d     = S_Q;
          end
        end
      end
      S_FEED: begin
        cmd_o.feed = 1'b1;
        if (sts_i.go_parse) begin
          cmd_o.p1_init = 1'b1;
          state_d       = S_P1_RD;
        end else begin
          cmd_o.k_clr = 1'b1;
          state_d     = S_Q;
        end
      end
      S_P1_RD: state_d = S_P1_DT;
      S_P1_DT: begin
        cmd_o.p1_step = 1'b1;
        state_d       = sts_i.p1_last ? S_P1_END : S_P1_RD;
      end
      S_P1_END: begin
        if (sts_i.cks_ok) begin
          cmd_o.p2_init = 1'b1;
          state_d       = S_P2_RD;
        end else begin
          cmd_o.k_clr = 1'b1;
          state_d     = S_Q;
        end
      end
      S_P2_RD: state_d = S_P2_DT;
      S_P2_DT: begin
        cmd_o.p2_step = 1'b1;
        if (sts_i.p2_store) begin
          cmd_o.k_clr = 1'b1;
          state_d     = S_SRCH;
        end else if (sts_i.p2_end) begin
          cmd_o.k_clr = 1'b1;
          state_d     = S_Q;
        end else begin
          state_d = S_P2_RD;
        end
      end
      S_SRCH: begin
        cmd_o.srch_step = 1'b1;
        if (sts_i.srch_done) begin
          cmd_o.k_clr = 1'b1;
          state_d     = sts_i.p2_end_q ? S_Q : S_P2_RD;
        end else if (sts_i.srch_full) begin
          cmd_o.k_clr = 1'b1;
          state_d     = S_REUSE;
        end
      end
      S_REUSE: begin
        cmd_o.reuse_step = 1'b1;
        if (sts_i.reuse_done) begin
          cmd_o.k_clr = 1'b1;
          state_d     = sts_i.p2_end_q ? S_Q : S_P2_RD;
        end
      end
      S_Q: begin
        if (sts_i.q_done) begin
          if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.q_step = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* rtl/ngst_dp.sv */
// datapath of the gsv tracker: framing, sentence buffer, parser, table, query
// depends on ngst_pkg and ngst_ram
`timescale 1ns / 1ps
module ngst_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ngst_pkg::cmd_t cmd_i,
  output ngst_pkg::sts_t sts_o,
  input  logic [31:0]    ttl_ms_i,
  input  logic [1:0]     action_i,
  input  logic [7:0]     byte_value_i,
  input  logic [31:0]    now_ms_i,
  input  logic [7:0]     cno_threshold_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [5:0]     live_count_o,
  output logic [7:0]     best_cno_o,
  output logic [5:0]     strong_count_o,
  output logic [5:0]     entries_used_o,
  output logic [15:0]    overflow_count_o
);
  import ngst_pkg::*;

  // item registers
  logic [7:0]  byte_q, thr_q;
  logic [31:0] now_q;

  // framing and buffer
  logic [BCNT_W-1:0] count_q, n_q, idx_q;
  logic              in_sent_q;
  logic              buf_we;
  logic [7:0]        rdata;

  // checksum pass
  logic              star_found_q, gsv_bad_q;
  logic [BCNT_W-1:0] star_idx_q;
  logic [7:0]        xor_q, tal_hi_q, tal_lo_q, hi_c_q, lo_c_q;

  // field pass
  logic [7:0]     field_q;
  logic [V_W-1:0] v_q;
  logic           vok_q, vlen_q, id_ok_q, p2_end_q;
  logic [15:0]    id_q, st_svid_q;
  logic [7:0]     st_cno_q;

  // table
  logic [15:0]       e_talker_q [MAX_SATS];
  logic [15:0]       e_svid_q   [MAX_SATS];
  logic [7:0]        e_cno_q    [MAX_SATS];
  logic [31:0]       e_seen_q   [MAX_SATS];
  logic [SCNT_W-1:0] used_q, k_q;
  logic [15:0]       lost_q;
  logic              tbl_we;
  logic [SAT_AW-1:0] tbl_widx;

  // query accumulators
  logic [SCNT_W-1:0] live_q, strong_q;
  logic [7:0]        best_q;

  logic [SAT_AW-1:0] ki;
  logic              k_in, k_live, k_match, sep, eol;
  logic [15:0]       talker;
  logic [VX_W-1:0]   vn;
  logic              fok;

  assign ki      = k_q[SAT_AW-1:0];
  assign k_in    = k_q < used_q;
  assign k_live  = (now_q - e_seen_q[ki]) < ttl_ms_i;
  assign talker  = {tal_hi_q, tal_lo_q};
  assign k_match = (e_talker_q[ki] == talker) && (e_svid_q[ki] == st_svid_q);
  assign sep     = (rdata == CH_COMMA) || (rdata == CH_STAR);
  assign eol     = (byte_q == CH_CR) || (byte_q == CH_LF);
  assign fok     = vok_q && vlen_q;
  assign vn      = VX_W'(v_q) * VX_W'(10) + VX_W'(rdata[3:0]);

  // sentence buffer
  ngst_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_buf (
    .clk_i  (clk_i),
    .we_i   (buf_we),
    .waddr_i(count_q[BUF_AW-1:0]),
    .wdata_i(byte_q),
    .raddr_i(idx_q[BUF_AW-1:0]),
    .rdata_o(rdata)
  );

  assign buf_we = cmd_i.feed && byte_q != CH_DOLLAR && in_sent_q && !eol &&
                  count_q < BCNT_W'(BUF_BYTES);

  // status to the controller
  always_comb begin
    sts_o.action     = action_e'(action_i);
    sts_o.go_parse   = byte_q != CH_DOLLAR && in_sent_q && eol && count_q != '0;
    sts_o.p1_last    = (idx_q + 1'b1) == n_q;
    sts_o.cks_ok     = n_q >= BCNT_W'(6) && !gsv_bad_q && star_found_q &&
                       star_idx_q != '0 && n_q == star_idx_q + BCNT_W'(3) &&
                       is_hex(hi_c_q) && is_hex(lo_c_q) &&
                       xor_q == {hex_val(hi_c_q), hex_val(lo_c_q)};
    sts_o.p2_store   = sep && field_q >= 8'd4 && field_q[1:0] == 2'd3 && id_ok_q;
    sts_o.p2_end     = rdata == CH_STAR;
    sts_o.p2_end_q   = p2_end_q;
    sts_o.srch_done  = (k_in && k_match) || (!k_in && used_q < SCNT_W'(MAX_SATS));
    sts_o.srch_full  = !k_in && used_q >= SCNT_W'(MAX_SATS);
    sts_o.reuse_done = !k_live || k_q == SCNT_W'(MAX_SATS - 1);
    sts_o.q_done     = !k_in;
    sts_o.out_free   = !out_valid_o || out_ready_i;
  end

  // table write selection
  always_comb begin
    tbl_we   = 1'b0;
    tbl_widx = ki;
    if (cmd_i.srch_step) begin
      if (k_in && k_match) begin
        tbl_we = 1'b1;
      end else if (!k_in && used_q < SCNT_W'(MAX_SATS)) begin
        tbl_we   = 1'b1;
        tbl_widx = used_q[SAT_AW-1:0];
      end
    end else if (cmd_i.reuse_step && !k_live) begin
      tbl_we = 1'b1;
    end
  end

  // table storage, only slots below the fill count are ever read
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      e_talker_q[tbl_widx] <= talker;
      e_svid_q[tbl_widx]   <= st_svid_q;
      e_cno_q[tbl_widx]    <= st_cno_q;
      e_seen_q[tbl_widx]   <= now_q;
    end
  end

  // item payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= byte_value_i;
      now_q  <= now_ms_i;
      thr_q  <= cno_threshold_i;
    end
  end

  // framing, fill count and overflow count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      in_sent_q <= 1'b0;
      used_q    <= '0;
      lost_q    <= '0;
    end else begin
      if (cmd_i.load && action_e'(action_i) == ACT_CLEAR) begin
        count_q   <= '0;
        in_sent_q <= 1'b0;
        used_q    <= '0;
        lost_q    <= '0;
      end
      if (cmd_i.feed) begin
        if (byte_q == CH_DOLLAR) begin
          count_q   <= '0;
          in_sent_q <= 1'b1;
        end else if (in_sent_q) begin
          if (eol || count_q >= BCNT_W'(BUF_BYTES)) begin
            count_q   <= '0;
            in_sent_q <= 1'b0;
          end else begin
            count_q <= count_q + 1'b1;
          end
        end
      end
      if (cmd_i.srch_step && !k_in && used_q < SCNT_W'(MAX_SATS)) begin
        used_q <= used_q + 1'b1;
      end
      if (cmd_i.reuse_step && k_live && k_q == SCNT_W'(MAX_SATS - 1) &&
          lost_q != LOST_MAX) begin
        lost_q <= lost_q + 1'b1;
      end
    end
  end

  // parser passes
  always_ff @(posedge clk_i) begin
    if (cmd_i.feed) begin
      n_q <= count_q;
    end
    if (cmd_i.p1_init || cmd_i.p2_init) begin
      idx_q <= '0;
    end else if (cmd_i.p1_step || cmd_i.p2_step) begin
      idx_q <= idx_q + 1'b1;
    end
    // checksum and header pass
    if (cmd_i.p1_init) begin
      star_found_q <= 1'b0;
      gsv_bad_q    <= 1'b0;
      xor_q        <= '0;
      star_idx_q   <= '0;
    end else if (cmd_i.p1_step) begin
      if (!star_found_q) begin
        if (rdata == CH_STAR) begin
          star_found_q <= 1'b1;
          star_idx_q   <= idx_q;
        end else begin
          xor_q <= xor_q ^ rdata;
        end
      end
      if (idx_q == BCNT_W'(0)) tal_hi_q <= rdata;
      if (idx_q == BCNT_W'(1)) tal_lo_q <= rdata;
      if ((idx_q == BCNT_W'(2) && rdata != CH_G) || (idx_q == BCNT_W'(3) && rdata != CH_S) ||
          (idx_q == BCNT_W'(4) && rdata != CH_V) || (idx_q == BCNT_W'(5) && rdata != CH_COMMA)) begin
        gsv_bad_q <= 1'b1;
      end
      if (star_found_q && idx_q == star_idx_q + 1'b1) hi_c_q <= rdata;
      if (star_found_q && idx_q == star_idx_q + BCNT_W'(2)) lo_c_q <= rdata;
    end
    // field pass
    if (cmd_i.p2_init) begin
      field_q  <= '0;
      v_q      <= '0;
      vok_q    <= 1'b1;
      vlen_q   <= 1'b0;
      id_ok_q  <= 1'b0;
      p2_end_q <= 1'b0;
    end else if (cmd_i.p2_step) begin
      if (sep) begin
        if (field_q >= 8'd4) begin
          if (field_q[1:0] == 2'd0) begin
            id_ok_q <= fok;
            id_q    <= v_q[15:0];
          end else if (field_q[1:0] == 2'd3) begin
            st_svid_q <= id_q;
            st_cno_q  <= !fok ? 8'd0 :
                         (v_q > V_W'(CNO_MAX)) ? CNO_MAX : v_q[7:0];
            id_ok_q   <= 1'b0;
          end
        end
        field_q  <= field_q + 1'b1;
        v_q      <= '0;
        vok_q    <= 1'b1;
        vlen_q   <= 1'b0;
        p2_end_q <= rdata == CH_STAR;
      end else begin
        vlen_q <= 1'b1;
        if (vok_q) begin
          if (!is_digit(rdata) || vn > VX_W'(FIELD_LIMIT)) begin
            vok_q <= 1'b0;
          end else begin
            v_q <= vn[V_W-1:0];
          end
        end
      end
    end
  end

  // scan index over the table
  always_ff @(posedge clk_i) begin
    if (cmd_i.k_clr) begin
      k_q <= '0;
    end else if (cmd_i.srch_step || cmd_i.reuse_step || cmd_i.q_step) begin
      k_q <= k_q + 1'b1;
    end
  end

  // query accumulation
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      live_q   <= '0;
      strong_q <= '0;
      best_q   <= '0;
    end else if (cmd_i.q_step && k_live) begin
      live_q <= live_q + 1'b1;
      if (e_cno_q[ki] > best_q) best_q <= e_cno_q[ki];
      if (e_cno_q[ki] >= thr_q) strong_q <= strong_q + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      live_count_o     <= 6'(live_q);
      best_cno_o       <= best_q;
      strong_count_o   <= 6'(strong_q);
      entries_used_o   <= 6'(used_q);
      overflow_count_o <= lost_q;
    end
  end

endmodule

/* rtl/nmea_gsv_satellite_tracker_core.sv */
// top level of the gsv satellite tracker: apb register, controller, datapath
// depends on ngst_pkg, ngst_ctrl, ngst_dp and the assertion macro header
//
// Input beats carry an action (feed byte, query, clear), an nmea byte, the
// current millisecond time and a c/n0 threshold. Every accepted beat yields
// exactly one result beat: live count, best c/n0, strong count, slots in use
// and the overflow count, all taken after the beat's action is applied.
// One item at a time: in_ready_o is high only while the block is idle.
// A plain byte or query ends with the one-slot-per-cycle query scan over
// the slots in use. A byte ending a sentence adds a checksum pass and a
// field pass over the buffered bytes, and per stored satellite a search
// over the slots in use plus, when the table is full, a reuse scan.
// The result sits in an output register, so a stalled receiver does not stop
// the next item from being accepted; only the following result waits.
// Reset clears framing, fill count and overflow count and sets ttl_ms to
// 10000; no clearing pass is needed. The ttl register sits at address 0.
`timescale 1ns / 1ps
`include "nmea_gsv_satellite_tracker_core_macros.svh"
module nmea_gsv_satellite_tracker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  byte_value_i,
  input  logic [31:0] now_ms_i,
  input  logic [7:0]  cno_threshold_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  live_count_o,
  output logic [7:0]  best_cno_o,
  output logic [5:0]  strong_count_o,
  output logic [5:0]  entries_used_o,
  output logic [15:0] overflow_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ngst_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] ttl_q;

  // apb register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TTL) ? ttl_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= TTL_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TTL) begin
      ttl_q <= pwdata;
    end
  end

  ngst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ngst_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .ttl_ms_i        (ttl_q),
    .action_i        (action_i),
    .byte_value_i    (byte_value_i),
    .now_ms_i        (now_ms_i),
    .cno_threshold_i (cno_threshold_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .live_count_o    (live_count_o),
    .best_cno_o      (best_cno_o),
    .strong_count_o  (strong_count_o),
    .entries_used_o  (entries_used_o),
    .overflow_count_o(overflow_count_o)
  );

  // checks
  `NGST_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `NGST_ASSERT_IMP(a_counts_ordered, out_valid_o,
                   live_count_o <= entries_used_o && strong_count_o <= live_count_o)
  `NGST_ASSERT_IMP(a_best_needs_live, out_valid_o && best_cno_o != 8'd0,
                   live_count_o != 6'd0)

endmodule

/* tb/tb.sv */
// self-checking testbench for the gsv satellite tracker core
// depends on ngst_pkg and nmea_gsv_satellite_tracker_core
// feeds framed gsv sentences, noise, queries and clears and checks every result beat
`timescale 1ns / 1ps
module tb;
  import ngst_pkg::*;

  typedef struct packed {
    logic [5:0]  live;
    logic [7:0]  best;
    logic [5:0]  above;
    logic [5:0]  used;
    logic [15:0] lost;
  } sky_t;

  typedef struct {
    action_e    act;
    logic [7:0] chr;
    logic [31:0] now;
    logic [7:0] thr;
    bit         typed;
    sky_t       res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = ACT_QUERY;
  logic [7:0]  byte_value_i = '0;
  logic [31:0] now_ms_i = '0;
  logic [7:0]  cno_threshold_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [5:0]  live_count_o;
  logic [7:0]  best_cno_o;
  logic [5:0]  strong_count_o;
  logic [5:0]  entries_used_o;
  logic [15:0] overflow_count_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  nmea_gsv_satellite_tracker_core dut (.*);

  always #5 clk_i = ~clk_i;

  // tracker model state
  logic [31:0] ttl_q;
  logic [7:0]  line_buf [BUF_BYTES];
  int          line_len;
  bit          in_line;
  logic [15:0] sat_talker [MAX_SATS];
  logic [15:0] sat_id [MAX_SATS];
  logic [7:0]  sat_cno [MAX_SATS];
  logic [31:0] sat_seen [MAX_SATS];
  int          slots_used;
  logic [15:0] sats_lost;

  sky_t        sky_q[$];
  int          errors = 0;
  bit          calm = 1'b0;
  bit          hold_go = 1'b0;
  logic [31:0] clock_ms;
  logic [7:0]  text_q[$];

  function automatic void wipe_tracker();
    line_len = 0;
    in_line = 0;
    slots_used = 0;
    sats_lost = '0;
    for (int k = 0; k < MAX_SATS; k++) begin
      sat_talker[k] = '0; sat_id[k] = '0; sat_cno[k] = '0; sat_seen[k] = '0;
    end
  endfunction

  function automatic bit is_alive(int k, logic [31:0] now);
    logic [31:0] age;
    age = now - sat_seen[k];
    return age < ttl_q;
  endfunction

  function automatic int hex_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return -1;
  endfunction

  function automatic void place_sat(int k, logic [15:0] tk, logic [15:0] id,
                                    logic [7:0] cn, logic [31:0] now);
    sat_talker[k] = tk; sat_id[k] = id; sat_cno[k] = cn; sat_seen[k] = now;
  endfunction

  // refresh, append, reuse an expired slot, or count as lost
  function automatic void record_sat(logic [15:0] tk, logic [15:0] id,
                                     logic [7:0] cn, logic [31:0] now);
    for (int k = 0; k < slots_used; k++) begin
      if (sat_talker[k] == tk && sat_id[k] == id) begin
        sat_cno[k] = cn;
        sat_seen[k] = now;
        return;
      end
    end
    if (slots_used < MAX_SATS) begin
      place_sat(slots_used, tk, id, cn, now);
      slots_used++;
      return;
    end
    for (int k = 0; k < MAX_SATS; k++) begin
      if (!is_alive(k, now)) begin
        place_sat(k, tk, id, cn, now);
        return;
      end
    end
    if (sats_lost != LOST_MAX) sats_lost++;
  endfunction

  function automatic bit sum_ok(int n);
    int star, hi, lo;
    logic [7:0] x;
    star = n;
    x = '0;
    for (int k = 0; k < n; k++) begin
      if (line_buf[k] == CH_STAR) begin
        star = k;
        break;
      end
    end
    if (star == n || star == 0 || n - star != 3) return 0;
    hi = hex_of(line_buf[star + 1]);
    lo = hex_of(line_buf[star + 2]);
    if (hi < 0 || lo < 0) return 0;
    for (int k = 0; k < star; k++) x ^= line_buf[k];
    return x == 8'(hi * 16 + lo);
  endfunction

  // walk the quads of an accepted gsv sentence
  function automatic void parse_line(logic [31:0] now);
    int n, i, field, start;
    logic [31:0] v, id_v;
    logic [7:0] c, cn;
    bit ok, id_ok;
    logic [15:0] tk;
    n = line_len;
    i = 0;
    field = 0;
    id_ok = 0;
    id_v = '0;
    if (n < 6) return;
    if (line_buf[2] != CH_G || line_buf[3] != CH_S || line_buf[4] != CH_V ||
        line_buf[5] != CH_COMMA) return;
    if (!sum_ok(n)) return;
    tk = {line_buf[0], line_buf[1]};
    while (1) begin
      start = i;
      v = '0;
      while (i < n && line_buf[i] != CH_COMMA && line_buf[i] != CH_STAR) i++;
      if (field >= 4) begin
        ok = i > start;
        for (int k = start; ok && k < i; k++) begin
          c = line_buf[k];
          if (c < "0" || c > "9") ok = 0;
          else begin
            v = v * 10 + 32'(c - "0");
            if (v > FIELD_LIMIT) ok = 0;
          end
        end
        if ((field - 4) % 4 == 0) begin
          id_ok = ok;
          id_v = v;
        end else if ((field - 4) % 4 == 3) begin
          if (id_ok) begin
            cn = !ok ? 8'd0 : (v > 255 ? CNO_MAX : v[7:0]);
            record_sat(tk, id_v[15:0], cn, now);
          end
          id_ok = 0;
        end
      end
      if (i >= n || line_buf[i] == CH_STAR) break;
      i++;
      field++;
    end
  endfunction

  function automatic void take_char(logic [7:0] c, logic [31:0] now);
    if (c == CH_DOLLAR) begin
      line_len = 0;
      in_line = 1;
      return;
    end
    if (!in_line) return;
    if (c == CH_CR || c == CH_LF) begin
      if (line_len != 0) parse_line(now);
      line_len = 0;
      in_line = 0;
      return;
    end
    if (line_len >= BUF_BYTES) begin
      line_len = 0;
      in_line = 0;
      return;
    end
    line_buf[line_len] = c;
    line_len++;
  endfunction

  function automatic sky_t track_step(logic [1:0] act, logic [7:0] c,
                                      logic [31:0] now, logic [7:0] thr);
    sky_t r;
    r = '0;
    if (act == ACT_FEED) take_char(c, now);
    else if (act == ACT_CLEAR) wipe_tracker();
    for (int k = 0; k < slots_used; k++) begin
      if (is_alive(k, now)) begin
        r.live++;
        if (sat_cno[k] > r.best) r.best = sat_cno[k];
        if (sat_cno[k] >= thr) r.above++;
      end
    end
    r.used = 6'(slots_used);
    r.lost = sats_lost;
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  // input beats: predict on acceptance
  bit typed_next = 0;
  sky_t typed_res;
  always @(posedge clk_i) begin
    sky_t p;
    if (in_valid_i && in_ready_o) begin
      p = track_step(action_i, byte_value_i, now_ms_i, cno_threshold_i);
      sky_q.push_back(typed_next ? typed_res : p);
    end
  end

  // result beats: compare field by field against the oldest expectation
  always @(posedge clk_i) begin
    sky_t e;
    if (out_valid_o && out_ready_i) begin
      if (sky_q.size() == 0) report("unexpected result beat", 1, 0);
      else begin
        e = sky_q.pop_front();
        if (live_count_o != e.live) report("live_count", live_count_o, e.live);
        if (best_cno_o != e.best) report("best_cno", best_cno_o, e.best);
        if (strong_count_o != e.above) report("strong_count", strong_count_o, e.above);
        if (entries_used_o != e.used) report("entries_used", entries_used_o, e.used);
        if (overflow_count_o != e.lost)
          report("overflow_count", overflow_count_o, e.lost);
      end
    end
  end

  // receiver: random stalls, calm stretch, one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else out_ready_i <= calm || $urandom_range(0, 99) >= 12;
    end
  end

  task automatic send(logic [1:0] act, logic [7:0] c, logic [31:0] now, logic [7:0] thr);
    if (!calm && $urandom_range(0, 99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    byte_value_i <= c;
    now_ms_i <= now;
    cno_threshold_i <= thr;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // clock the last accepted beat in first so it is already queued
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (sky_q.size() == 0);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_ttl(logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 3'(4 * int'(REG_TTL)); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    ttl_q = val;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic void put_text(string s);
    for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
  endfunction

  // feed the queued characters as beats with a slowly advancing clock
  task automatic feed_text();
    while (text_q.size() != 0) begin
      clock_ms += $urandom_range(0, 40);
      if ($urandom_range(0, 99) < 2) clock_ms += 15000;
      send(ACT_FEED, text_q.pop_front(), clock_ms, 8'($urandom_range(0, 255)));
    end
  endtask

  function automatic string rand_num();
    case ($urandom_range(0, 9))
      0: return "";
      1: return "70001";
      2: return "123456";
      3: return "1x";
      default: return $sformatf("%0d", $urandom_range(1, 40));
    endcase
  endfunction

  function automatic string rand_cno();
    case ($urandom_range(0, 7))
      0: return "";
      1: return "300";
      2: return "4a";
      3: return "00255";
      default: return $sformatf("%0d", $urandom_range(0, 60));
    endcase
  endfunction

  // one framed sentence: mostly valid gsv, sometimes broken or too long
  task automatic build_sentence();
    string body, tail, tks[4];
    logic [7:0] x;
    int quads;
    tks = '{"GP", "GL", "GA", "BD"};
    x = '0;
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 19) == 0)
      body = {string'(8'($urandom_range(33, 126))), string'(8'($urandom_range(33, 126)))};
    else body = tks[$urandom_range(0, 3)];
    body = {body, ($urandom_range(0, 9) == 0) ? "GSA," : "GSV,", "3,1,12"};
    quads = $urandom_range(0, 9) == 0 ? $urandom_range(5, 8) : $urandom_range(0, 4);
    for (int q = 0; q < quads; q++) begin
      body = {body, ",", rand_num(), ",", ($urandom_range(0, 1) ? "" : "45"), ",",
              ($urandom_range(0, 1) ? "" : "270"), ",", rand_cno()};
    end
    if ($urandom_range(0, 9) == 0) body = {body, ",", rand_num()};
    if ($urandom_range(0, 19) == 0)
      for (int k = 0; k < 130; k++) body = {body, "1"};
    for (int k = 0; k < body.len(); k++) x ^= body[k];
    case ($urandom_range(0, 9))
      0: x ^= 8'h01;
      1: tail = "";
      default: ;
    endcase
    if (tail != "" || x != '0 || 1) begin
      tail = $urandom_range(0, 1) ? $sformatf("*%02X", x) : $sformatf("*%02x", x);
    end
    if ($urandom_range(0, 19) == 0) tail = "";
    put_text({"$", body, tail});
    case ($urandom_range(0, 2))
      0: text_q.push_back(CH_CR);
      1: text_q.push_back(CH_LF);
      default: begin
        text_q.push_back(CH_CR);
        text_q.push_back(CH_LF);
      end
    endcase
  endtask

  row_t rows[$];
  logic [31:0] ttl_plan[5] = '{32'hFFFF_FFFF, 32'd1, 32'd0, 32'd3000, TTL_RESET};
  int beats;

  initial begin
    ttl_q = TTL_RESET;
    wipe_tracker();
    clock_ms = 32'hFFFF_F000;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows: empty table answers zero everywhere
    rows.push_back('{ACT_QUERY, 8'h00, 32'd0, 8'd0, 1, '0});
    rows.push_back('{ACT_RSVD, 8'hFF, 32'hFFFF_FFFF, 8'd255, 1, '0});
    rows.push_back('{ACT_CLEAR, 8'h55, 32'd12345, 8'd10, 1, '0});
    rows.push_back('{ACT_FEED, 8'hFF, 32'd1, 8'd0, 1, '0});
    rows.push_back('{ACT_FEED, 8'h00, 32'd2, 8'd0, 1, '0});
    rows.push_back('{ACT_FEED, CH_LF, 32'd3, 8'd0, 1, '0});
    rows.push_back('{ACT_FEED, CH_DOLLAR, 32'd4, 8'd0, 1, '0});
    rows.push_back('{ACT_FEED, CH_CR, 32'd5, 8'd0, 1, '0});
    foreach (rows[r]) begin
      typed_next = rows[r].typed;
      typed_res = rows[r].res;
      send(rows[r].act, rows[r].chr, rows[r].now, rows[r].thr);
    end
    typed_next = 0;
    drain();

    // directed sentence: blank id, saturating, invalid and blank c/n0, wide id
    put_text("$GPGSV,1,1,05,07,10,20,45,,,,30,70001,,,300,08,,,4a,09,,,");
    begin
      logic [7:0] x;
      string s;
      x = '0;
      s = "GPGSV,1,1,05,07,10,20,45,,,,30,70001,,,300,08,,,4a,09,,,";
      for (int k = 0; k < s.len(); k++) x ^= s[k];
      put_text($sformatf("*%02X", x));
      text_q.push_back(CH_CR);
    end
    feed_text();
    send(ACT_QUERY, 8'h00, clock_ms, 8'd255);

    // random phases over several ttl settings
    beats = 0;
    for (int p = 0; p < 5; p++) begin
      drain();
      write_ttl(ttl_plan[p]);
      for (int s = 0; s < 3; s++) begin
        calm = (p == 1);
        if (p == 2 && s == 1) hold_go = 1;
        build_sentence();
        beats += text_q.size();
        feed_text();
        if ($urandom_range(0, 3) == 0)
          send($urandom_range(0, 1) ? ACT_QUERY : ACT_RSVD, 8'($urandom_range(0, 255)),
               $urandom(), 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 29) == 0)
          send(ACT_CLEAR, 8'($urandom_range(0, 255)), clock_ms, 8'($urandom_range(0, 255)));
      end
      calm = 0;
    end
    while (beats < 600) begin
      build_sentence();
      beats += text_q.size();
      feed_text();
    end
    drain();

    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
